### rtl/llbc_pkg.sv
package llbc_pkg;

    // Command bytes carried by one input transaction
    localparam int IN_CMD_BYTES = 4;
    localparam int CMD_BYTES_DEF = 4;

    // Register reset values
    localparam logic [15:0] MAX_PACKET_RST = 16'd31;
    localparam logic [7:0]  POST_WAIT_RST  = 8'd15;
    localparam logic [7:0]  READ_GAP_RST   = 8'd10;

    // Configuration address map (byte address = 4 * index)
    localparam int CFG_ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_MAX_PACKET = 2'd0,
        REG_POST_WAIT  = 2'd1,
        REG_READ_GAP   = 2'd2,
        REG_NONE       = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SEND  = 2'd1,
        OP_READ  = 2'd2,
        OP_RSVD  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CHECKSUM = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_RSVD     = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_S_ACK    = 5'd1,
        PH_S_LOW    = 5'd2,
        PH_S_HIGH   = 5'd3,
        PH_S_POST   = 5'd4,
        PH_S_REL    = 5'd5,
        PH_S_HS     = 5'd6,
        PH_CK_LOW   = 5'd7,
        PH_CK_HIGH  = 5'd8,
        PH_P_WAIT0  = 5'd9,
        PH_L0_LOW   = 5'd10,
        PH_L0_HIGH  = 5'd11,
        PH_P_RISE_L = 5'd12,
        PH_P_RISE_H = 5'd13,
        PH_L1_LOW   = 5'd14,
        PH_L1_HIGH  = 5'd15,
        PH_P_LOWW   = 5'd16,
        PH_P_DHIGH  = 5'd17,
        PH_D_LOW    = 5'd18,
        PH_D_HIGH   = 5'd19,
        PH_P_GAP    = 5'd20
    } phase_t;

    typedef struct packed {
        logic [15:0] max_packet_bytes;
        logic [7:0]  post_write_wait_ticks;
        logic [7:0]  read_gap_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                   op;
        logic [IN_CMD_BYTES-1:0][7:0] cmd_bytes;
        logic                         lens_hsk;
        logic                         data_in;
    } item_t;

    typedef struct packed {
        logic        clk_line;
        logic        data_out;
        logic        data_drive;
        logic        body_hsk;
        logic [7:0]  rx_byte;
        logic        rx_valid;
        logic        rx_last;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
        logic [15:0] packet_length;
    } result_t;

endpackage

### rtl/lens_link_body_controller.sv
// Path: an accepted transaction is held in the input register, then its state step
// is registered into the result register. Throughput: one transaction per cycle
// while the consumer takes results; the single state step per tick sets this.
// Reset: aresetn is synchronous, active low; the link returns to idle, registers
// take 31 / 15 / 10, and both pipeline registers empty. No clearing pass.
module lens_link_body_controller
    import llbc_pkg::*;
#(
    parameter int CMD_BYTES = CMD_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // tick input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_op,
    input  logic [7:0]            s_cmd_byte0,
    input  logic [7:0]            s_cmd_byte1,
    input  logic [7:0]            s_cmd_byte2,
    input  logic [7:0]            s_cmd_byte3,
    input  logic                  s_lens_hsk,
    input  logic                  s_data_in,
    // result output
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_clk_line,
    output logic                  m_data_out,
    output logic                  m_data_drive,
    output logic                  m_body_hsk,
    output logic [7:0]            m_rx_byte,
    output logic                  m_rx_valid,
    output logic                  m_rx_last,
    output logic                  m_busy_res,
    output logic                  m_done_res,
    output logic [1:0]            m_status,
    output logic [15:0]           m_packet_length
);

    cfg_t    cfg;
    item_t   in_reg;
    logic    in_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    m_valid_reg;
    logic    advance;

    llbc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The held tick moves into the state machine whenever the result slot
    // is free or being drained this cycle; the input slot refills behind it.
    assign advance = in_valid_reg & (~m_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.op        <= s_op;
            in_reg.cmd_bytes <= {s_cmd_byte3, s_cmd_byte2, s_cmd_byte1, s_cmd_byte0};
            in_reg.lens_hsk  <= s_lens_hsk;
            in_reg.data_in   <= s_data_in;
        end
    end

    // One protocol step per tick; state only moves when the tick advances.
    llbc_core #(
        .CMD_BYTES (CMD_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_reg),
        .cfg     (cfg),
        .result  (res_next)
    );

    // Result register: holds the step's outputs until the consumer takes them.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_clk_line      = res_reg.clk_line;
    assign m_data_out      = res_reg.data_out;
    assign m_data_drive    = res_reg.data_drive;
    assign m_body_hsk      = res_reg.body_hsk;
    assign m_rx_byte       = res_reg.rx_byte;
    assign m_rx_valid      = res_reg.rx_valid;
    assign m_rx_last       = res_reg.rx_last;
    assign m_busy_res      = res_reg.busy_res;
    assign m_done_res      = res_reg.done_res;
    assign m_status        = res_reg.status;
    assign m_packet_length = res_reg.packet_length;

endmodule

### rtl/llbc_cfg.sv
module llbc_cfg
    import llbc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [15:0] max_packet_reg;
    logic [7:0]  post_wait_reg;
    logic [7:0]  read_gap_reg;
    logic        wr_en;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_packet_reg <= MAX_PACKET_RST;
            post_wait_reg  <= POST_WAIT_RST;
            read_gap_reg   <= READ_GAP_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_MAX_PACKET: max_packet_reg <= pwdata[15:0];
                REG_POST_WAIT:  post_wait_reg  <= pwdata[7:0];
                REG_READ_GAP:   read_gap_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_MAX_PACKET: prdata = {16'd0, max_packet_reg};
            REG_POST_WAIT:  prdata = {24'd0, post_wait_reg};
            REG_READ_GAP:   prdata = {24'd0, read_gap_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg.max_packet_bytes      = max_packet_reg;
    assign cfg.post_write_wait_ticks = post_wait_reg;
    assign cfg.read_gap_ticks        = read_gap_reg;

endmodule

### rtl/llbc_core.sv
module llbc_core
    import llbc_pkg::*;
#(
    parameter int CMD_BYTES = CMD_BYTES_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    localparam int IDX_W = (CMD_BYTES > 1) ? $clog2(CMD_BYTES) : 1;

    phase_t      phase_reg, phase_next;
    logic [2:0]  bit_count_reg, bit_count_next;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] length_reg, length_next;
    logic [7:0]  wait_count_reg, wait_count_next;
    logic [7:0]  cmd_store_reg [CMD_BYTES];

    logic        store_load;
    logic [15:0] bc_inc;
    logic [7:0]  store_rd;
    logic [7:0]  wait_dec;
    logic [7:0]  shift_in;
    logic        rx_valid, rx_last, done;
    logic [1:0]  status;
    logic [15:0] len;

    assign bc_inc   = byte_count_reg + 16'd1;
    assign store_rd = cmd_store_reg[bc_inc[IDX_W-1:0]];
    assign wait_dec = wait_count_reg - 8'd1;
    assign shift_in = {item.data_in, shift_reg[7:1]};

    // next state
    always_comb begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        byte_count_next = byte_count_reg;
        shift_next      = shift_reg;
        sum_next        = sum_reg;
        length_next     = length_reg;
        wait_count_next = wait_count_reg;
        store_load      = 1'b0;
        rx_valid        = 1'b0;
        rx_last         = 1'b0;
        done            = 1'b0;
        status          = ST_OK;
        len             = 16'd0;

        unique case (phase_reg)
            PH_IDLE: begin
                if (item.op == OP_SEND) begin
                    store_load      = 1'b1;
                    byte_count_next = 16'd0;
                    bit_count_next  = 3'd0;
                    shift_next      = item.cmd_bytes[0];
                    sum_next        = item.cmd_bytes[0];
                    phase_next      = PH_S_ACK;
                end else if (item.op == OP_READ) begin
                    length_next     = 16'd0;
                    byte_count_next = 16'd0;
                    phase_next      = PH_P_WAIT0;
                end
            end
            PH_S_ACK: begin
                if (item.lens_hsk) begin
                    bit_count_next = 3'd0;
                    phase_next     = PH_S_LOW;
                end
            end
            PH_S_LOW: phase_next = PH_S_HIGH;
            PH_S_HIGH, PH_S_POST: begin
                if (phase_reg == PH_S_HIGH && bit_count_reg != 3'd7) begin
                    bit_count_next = bit_count_reg + 3'd1;
                    shift_next     = {1'b0, shift_reg[7:1]};
                    phase_next     = PH_S_LOW;
                end else if (phase_reg == PH_S_HIGH && cfg.post_write_wait_ticks != 8'd0) begin
                    bit_count_next  = 3'd0;
                    wait_count_next = cfg.post_write_wait_ticks;
                    phase_next      = PH_S_POST;
                end else begin
                    if (phase_reg == PH_S_HIGH) bit_count_next = 3'd0;
                    else wait_count_next = wait_dec;
                    if (phase_reg == PH_S_HIGH || wait_dec == 8'd0) begin
                        // byte done: load the next command byte or hand over the line
                        byte_count_next = bc_inc;
                        if (bc_inc < 16'(CMD_BYTES)) begin
                            shift_next     = store_rd;
                            sum_next       = sum_reg + store_rd;
                            bit_count_next = 3'd0;
                            phase_next     = PH_S_LOW;
                        end else begin
                            phase_next = PH_S_REL;
                        end
                    end
                end
            end
            PH_S_REL: if (!item.lens_hsk) phase_next = PH_S_HS;
            PH_S_HS: begin
                if (item.lens_hsk) begin
                    shift_next     = 8'd0;
                    bit_count_next = 3'd0;
                    phase_next     = PH_CK_LOW;
                end
            end
            PH_CK_LOW: begin
                shift_next = shift_in;
                phase_next = PH_CK_HIGH;
            end
            PH_L0_LOW: begin
                shift_next = shift_in;
                phase_next = PH_L0_HIGH;
            end
            PH_L1_LOW: begin
                shift_next = shift_in;
                phase_next = PH_L1_HIGH;
            end
            PH_D_LOW: begin
                shift_next = shift_in;
                phase_next = PH_D_HIGH;
            end
            PH_CK_HIGH, PH_L0_HIGH, PH_L1_HIGH, PH_D_HIGH: begin
                if (bit_count_reg != 3'd7) begin
                    bit_count_next = bit_count_reg + 3'd1;
                    phase_next     = phase_t'(phase_reg - 5'd1);
                end else begin
                    bit_count_next = 3'd0;
                    unique case (phase_reg)
                        PH_CK_HIGH: begin
                            done       = 1'b1;
                            status     = (sum_reg != shift_reg) ? ST_CHECKSUM : ST_OK;
                            phase_next = PH_IDLE;
                        end
                        PH_L0_HIGH: begin
                            length_next = {8'd0, shift_reg};
                            phase_next  = PH_P_RISE_L;
                        end
                        PH_L1_HIGH: begin
                            length_next = {shift_reg, length_reg[7:0]};
                            phase_next  = PH_P_LOWW;
                        end
                        default: begin
                            byte_count_next = bc_inc;
                            rx_valid        = 1'b1;
                            rx_last         = (bc_inc >= length_reg);
                            if (cfg.read_gap_ticks != 8'd0) begin
                                wait_count_next = cfg.read_gap_ticks;
                                phase_next      = PH_P_GAP;
                            end else if (bc_inc >= length_reg) begin
                                done       = 1'b1;
                                len        = length_reg;
                                phase_next = PH_IDLE;
                            end else begin
                                phase_next = PH_P_DHIGH;
                            end
                        end
                    endcase
                end
            end
            PH_P_WAIT0: begin
                if (item.lens_hsk) begin
                    shift_next     = 8'd0;
                    bit_count_next = 3'd0;
                    phase_next     = PH_L0_LOW;
                end
            end
            PH_P_RISE_L: if (!item.lens_hsk) phase_next = PH_P_RISE_H;
            PH_P_RISE_H: begin
                if (item.lens_hsk) begin
                    shift_next     = 8'd0;
                    bit_count_next = 3'd0;
                    phase_next     = PH_L1_LOW;
                end
            end
            PH_P_LOWW: begin
                if (!item.lens_hsk) begin
                    if (length_reg > cfg.max_packet_bytes) begin
                        done       = 1'b1;
                        status     = ST_TOO_LONG;
                        phase_next = PH_IDLE;
                    end else if (length_reg == 16'd0) begin
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                    end else begin
                        byte_count_next = 16'd0;
                        phase_next      = PH_P_DHIGH;
                    end
                end
            end
            PH_P_DHIGH: begin
                if (item.lens_hsk) begin
                    shift_next     = 8'd0;
                    bit_count_next = 3'd0;
                    phase_next     = PH_D_LOW;
                end
            end
            PH_P_GAP: begin
                wait_count_next = wait_dec;
                if (wait_dec == 8'd0) begin
                    if (byte_count_reg >= length_reg) begin
                        done       = 1'b1;
                        len        = length_reg;
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_P_DHIGH;
                    end
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // line levels and result fields after the step
    always_comb begin
        result.clk_line   = !(phase_next == PH_S_LOW || phase_next == PH_CK_LOW ||
                              phase_next == PH_L0_LOW || phase_next == PH_L1_LOW ||
                              phase_next == PH_D_LOW);
        result.data_drive = (phase_next == PH_S_ACK || phase_next == PH_S_LOW ||
                             phase_next == PH_S_HIGH || phase_next == PH_S_POST);
        result.data_out   = (phase_next == PH_S_LOW || phase_next == PH_S_HIGH) ?
                            shift_next[0] : 1'b0;
        result.body_hsk   = result.data_drive || phase_next == PH_S_REL ||
                            phase_next == PH_CK_LOW || phase_next == PH_CK_HIGH ||
                            phase_next == PH_L0_LOW || phase_next == PH_L0_HIGH ||
                            phase_next == PH_L1_LOW || phase_next == PH_L1_HIGH ||
                            phase_next == PH_D_LOW || phase_next == PH_D_HIGH;
        result.rx_byte       = rx_valid ? shift_next : 8'd0;
        result.rx_valid      = rx_valid;
        result.rx_last       = rx_last;
        result.busy_res      = (phase_next != PH_IDLE);
        result.done_res      = done;
        result.status        = status;
        result.packet_length = len;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= 3'd0;
            byte_count_reg <= 16'd0;
            shift_reg      <= 8'd0;
            sum_reg        <= 8'd0;
            length_reg     <= 16'd0;
            wait_count_reg <= 8'd0;
        end else if (step) begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            byte_count_reg <= byte_count_next;
            shift_reg      <= shift_next;
            sum_reg        <= sum_next;
            length_reg     <= length_next;
            wait_count_reg <= wait_count_next;
        end
    end

    // command bytes beyond the four carried by the item load as zero
    always_ff @(posedge aclk) begin
        if (step && store_load) begin
            for (int i = 0; i < CMD_BYTES; i++) begin
                cmd_store_reg[i] <= (i < IN_CMD_BYTES) ?
                                    item.cmd_bytes[i % IN_CMD_BYTES] : 8'd0;
            end
        end
    end

endmodule
